// ----- rtl/pps_pkg.sv -----
// Shared types, constants and helper functions of the Phong point light shader.
`default_nettype none
package pps_pkg;

  // Steps of the digit-by-digit square root and of the restoring divider.
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned DIV_STEPS  = 15;
  // Register stages of the vector normaliser: four set-up stages, the root,
  // the dividend stage, the quotient bits and the output register.
  localparam int unsigned NORM_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int unsigned POW_STEPS  = 32;
  localparam int unsigned PIPE_LAT   = 1 + NORM_LAT + 4 + NORM_LAT + 2 + POW_STEPS + 2;

  localparam logic [8:0]  AMBIENT_LEVEL = 9'd26;
  localparam logic [40:0] POW_ONE       = 41'd16384;
  localparam logic [40:0] POW_CAP       = 41'd1099511627776;

  typedef enum logic [3:0] {
    CFG_LIGHT_X    = 4'd0,
    CFG_LIGHT_Y    = 4'd1,
    CFG_LIGHT_Z    = 4'd2,
    CFG_COLOR_RED  = 4'd3,
    CFG_COLOR_GRN  = 4'd4,
    CFG_COLOR_BLU  = 4'd5,
    CFG_DIF_LEVEL  = 4'd6,
    CFG_SPEC_LEVEL = 4'd7
  } cfg_idx_e;

  typedef logic signed [47:0] wide_t;
  typedef logic signed [15:0] dir_t;

  // Data that rides alongside a vector through the normaliser.
  typedef struct packed {
    logic [2:0][15:0] nrm;
    logic [2:0][15:0] view;
    logic [16:0]      cd;
  } side_t;

  function automatic logic [5:0] lead_one(input logic [47:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  // Clamps a Q2.28 dot product at zero and rounds it to Q1.14.
  function automatic logic [16:0] clamp_dot(input logic signed [32:0] d);
    logic [32:0] t;
    t = 33'(d) + 33'd8192;
    if (d <= 33'sd0) begin
      return '0;
    end
    return t[30:14];
  endfunction

  function automatic logic [8:0] sat9(input logic [27:0] v);
    return (v > 28'd511) ? 9'd511 : v[8:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pps_normalize.sv -----
// Pipelined normaliser of a signed three-component vector to a Q1.14 unit vector.
`default_nettype none
module pps_normalize (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  pps_pkg::wide_t vec_i [3],
  input  pps_pkg::side_t side_i,
  output logic           valid_o,
  output pps_pkg::dir_t  dir_o [3],
  output pps_pkg::side_t side_o
);

  typedef struct packed {
    logic [2:0][47:0] mag;
    logic [2:0]       neg;
    logic [5:0]       pos;
    logic             zero;
    pps_pkg::side_t   side;
  } lz_t;

  typedef struct packed {
    logic [2:0][20:0] m;
    logic [2:0]       neg;
    logic             zero;
    pps_pkg::side_t   side;
  } mv_t;

  typedef struct packed {
    logic [2:0][41:0] sq;
    mv_t              mv;
  } sq_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
    mv_t         mv;
  } rt_t;

  typedef struct packed {
    logic [2:0][44:0] rem;
    logic [30:0]      len;
    logic [2:0][14:0] quo;
    logic [2:0]       neg;
    logic             zero;
    pps_pkg::side_t   side;
  } dv_t;

  lz_t           a_d, a_q;
  mv_t           b_d, b_q;
  sq_t           c_d, c_q;
  rt_t           rt_d;
  rt_t           rt_q [pps_pkg::SQRT_STEPS+1];
  dv_t           e_d;
  dv_t           dv_q [pps_pkg::DIV_STEPS+1];
  logic          a_vld_q, b_vld_q, c_vld_q;
  logic          rt_vld_q [pps_pkg::SQRT_STEPS+1];
  logic          dv_vld_q [pps_pkg::DIV_STEPS+1];
  logic          f_vld_q;
  pps_pkg::dir_t f_dir_d [3];
  pps_pkg::dir_t f_dir_q [3];
  pps_pkg::side_t f_side_q;
  logic [47:0]   a_or;
  logic [43:0]   d_sum;
  logic [14:0]   f_cap [3];

  // Magnitudes, and the leading one of their OR, which is that of the largest.
  always_comb begin
    a_or = '0;
    for (int j = 0; j < 3; j++) begin
      a_d.neg[j] = vec_i[j][47];
      a_d.mag[j] = vec_i[j][47] ? 48'(-vec_i[j]) : 48'(vec_i[j]);
      a_or       = a_or | a_d.mag[j];
    end
    a_d.pos  = pps_pkg::lead_one(a_or);
    a_d.zero = (a_or == '0);
    a_d.side = side_i;
  end

  // Bring the largest magnitude into [2^20, 2^21).
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (a_q.pos > 6'd20) begin
        b_d.m[j] = 21'(a_q.mag[j] >> (a_q.pos - 6'd20));
      end else begin
        b_d.m[j] = 21'(a_q.mag[j] << (6'd20 - a_q.pos));
      end
    end
    b_d.neg  = a_q.neg;
    b_d.zero = a_q.zero;
    b_d.side = a_q.side;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c_d.sq[j] = b_q.m[j] * b_q.m[j];
    end
    c_d.mv = b_q;
  end

  always_comb begin
    d_sum     = 44'(c_q.sq[0]) + 44'(c_q.sq[1]) + 44'(c_q.sq[2]);
    rt_d.rem  = '0;
    rt_d.root = '0;
    rt_d.rad  = {d_sum, 18'b0};
    rt_d.mv   = c_q.mv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      rt_vld_q[0] <= 1'b0;
    end else begin
      a_vld_q     <= valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      rt_vld_q[0] <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    rt_q[0]  <= rt_d;
  end

  // One root bit per stage, two radicand bits consumed each time.
  for (genvar k = 0; k < pps_pkg::SQRT_STEPS; k++) begin : g_sqrt
    logic [34:0] pre;
    logic [34:0] trial;
    rt_t         nxt;

    always_comb begin
      nxt     = rt_q[k];
      pre     = {rt_q[k].rem[32:0], rt_q[k].rad[61:60]};
      trial   = {2'b00, rt_q[k].root, 2'b01};
      nxt.rad = {rt_q[k].rad[59:0], 2'b00};
      if (pre >= trial) begin
        nxt.rem  = pre - trial;
        nxt.root = {rt_q[k].root[29:0], 1'b1};
      end else begin
        nxt.rem  = pre;
        nxt.root = {rt_q[k].root[29:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_vld_q[k+1] <= 1'b0;
      end else begin
        rt_vld_q[k+1] <= rt_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rt_q[k+1] <= nxt;
    end
  end

  // Dividend m * 2^23 plus half the length gives a rounded quotient.
  always_comb begin
    e_d.len = rt_q[pps_pkg::SQRT_STEPS].root;
    for (int j = 0; j < 3; j++) begin
      e_d.rem[j] = 45'({rt_q[pps_pkg::SQRT_STEPS].mv.m[j], 23'b0})
                 + 45'(rt_q[pps_pkg::SQRT_STEPS].root[30:1]);
    end
    e_d.quo  = '0;
    e_d.neg  = rt_q[pps_pkg::SQRT_STEPS].mv.neg;
    e_d.zero = rt_q[pps_pkg::SQRT_STEPS].mv.zero;
    e_d.side = rt_q[pps_pkg::SQRT_STEPS].mv.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= rt_vld_q[pps_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= e_d;
  end

  // Restoring division, one quotient bit per stage from the top.
  for (genvar i = 0; i < pps_pkg::DIV_STEPS; i++) begin : g_div
    localparam int unsigned B = pps_pkg::DIV_STEPS - 1 - i;
    logic [45:0] dvs;
    dv_t         nxt;

    always_comb begin
      nxt = dv_q[i];
      dvs = 46'(dv_q[i].len) << B;
      for (int j = 0; j < 3; j++) begin
        if ({1'b0, dv_q[i].rem[j]} >= dvs) begin
          nxt.rem[j]    = dv_q[i].rem[j] - dvs[44:0];
          nxt.quo[j][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i+1] <= 1'b0;
      end else begin
        dv_vld_q[i+1] <= dv_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[i+1] <= nxt;
    end
  end

  // A zero vector has no length; its quotient is discarded here.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      f_cap[j] = (dv_q[pps_pkg::DIV_STEPS].quo[j] > 15'd16384) ? 15'd16384
               : dv_q[pps_pkg::DIV_STEPS].quo[j];
      if (dv_q[pps_pkg::DIV_STEPS].zero) begin
        f_dir_d[j] = '0;
      end else if (dv_q[pps_pkg::DIV_STEPS].neg[j]) begin
        f_dir_d[j] = -{1'b0, f_cap[j]};
      end else begin
        f_dir_d[j] = {1'b0, f_cap[j]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= dv_vld_q[pps_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    f_dir_q  <= f_dir_d;
    f_side_q <= dv_q[pps_pkg::DIV_STEPS].side;
  end

  assign valid_o = f_vld_q;
  assign dir_o   = f_dir_q;
  assign side_o  = f_side_q;

`ifndef SYNTHESIS
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (dir_o[0] <= 16'sd16384 && dir_o[0] >= -16'sd16384 &&
                 dir_o[1] <= 16'sd16384 && dir_o[1] >= -16'sd16384 &&
                 dir_o[2] <= 16'sd16384 && dir_o[2] >= -16'sd16384))
    else $error("normalised component outside the unit range");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && vec_i[0] == '0 && vec_i[1] == '0 && vec_i[2] == '0)
      |-> ##(pps_pkg::NORM_LAT)
    (valid_o && dir_o[0] == '0 && dir_o[1] == '0 && dir_o[2] == '0))
    else $error("zero vector did not normalise to zero");
`endif

endmodule
`default_nettype wire

// ----- rtl/pps_power.sv -----
// Pipelined power of the specular cosine, one rounded multiply per stage.
`default_nettype none
module pps_power (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [16:0] cs_i,
  input  logic [16:0] cd_i,
  output logic        valid_o,
  output logic [40:0] pow_o,
  output logic [16:0] cd_o
);

  typedef struct packed {
    logic [40:0] p;
    logic [16:0] cs;
    logic [16:0] cd;
  } pw_t;

  pw_t  src;
  pw_t  pw_q  [pps_pkg::POW_STEPS];
  logic vld_q [pps_pkg::POW_STEPS];

  always_comb begin
    src.p  = pps_pkg::POW_ONE;
    src.cs = cs_i;
    src.cd = cd_i;
  end

  for (genvar k = 0; k < pps_pkg::POW_STEPS; k++) begin : g_pow
    pw_t         in_s;
    logic        in_v;
    logic [57:0] prod;
    logic [57:0] rnd;
    pw_t         nxt;

    if (k == 0) begin : g_first
      assign in_s = src;
      assign in_v = valid_i;
    end else begin : g_next
      assign in_s = pw_q[k-1];
      assign in_v = vld_q[k-1];
    end

    always_comb begin
      nxt   = in_s;
      prod  = in_s.p * in_s.cs;
      rnd   = prod + 58'd8192;
      nxt.p = (rnd[57:14] > 44'(pps_pkg::POW_CAP)) ? pps_pkg::POW_CAP : rnd[54:14];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= in_v;
      end
    end

    always_ff @(posedge clk_i) begin
      pw_q[k] <= nxt;
    end
  end

  assign valid_o = vld_q[pps_pkg::POW_STEPS-1];
  assign pow_o   = pw_q[pps_pkg::POW_STEPS-1].p;
  assign cd_o    = pw_q[pps_pkg::POW_STEPS-1].cd;

endmodule
`default_nettype wire

// ----- rtl/phong_point_light_shader_core.sv -----
// Top level of the Phong point light shader: registers, dot products and terms.
// Throughput: one item per cycle; busy_o stays low and results cannot be held off.
// The depth comes from two normalisers (31-step square root and 15-step divider
// each) and the 32-stage specular power chain.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and restores the
// configuration registers to their defaults; no clearing pass follows.
`default_nettype none
module phong_point_light_shader_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               done_o,
  output logic [8:0]         amb_red_o,
  output logic [8:0]         amb_green_o,
  output logic [8:0]         amb_blue_o,
  output logic [8:0]         dif_red_o,
  output logic [8:0]         dif_green_o,
  output logic [8:0]         dif_blue_o,
  output logic [8:0]         spec_red_o,
  output logic [8:0]         spec_green_o,
  output logic [8:0]         spec_blue_o
);

  // Above this power the specular term saturates for any non-zero colour and specular level.
  localparam logic [40:0] SPEC_CLIP = 41'd2147483648;

  logic               accept;
  logic signed [15:0] pt [3];
  logic signed [15:0] nin [3];
  logic signed [15:0] vin [3];
  logic signed [16:0] diff [3];

  logic signed [15:0] light_q [3];
  logic [8:0]         color_q [3];
  logic [8:0]         dif_lvl_q;
  logic [8:0]         spec_lvl_q;
  logic [17:0]        kd_q [3];
  logic [17:0]        ks_q [3];

  logic               s0_vld_q, s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic               s5_vld_q, s6_vld_q, f1_vld_q, f2_vld_q;
  pps_pkg::wide_t     s0_d_q [3];
  logic signed [15:0] s0_n_q [3];
  logic signed [15:0] s0_v_q [3];
  pps_pkg::side_t     n1_side_i, n1_side_o;
  logic               n1_vld;
  pps_pkg::dir_t      n1_dir [3];

  logic signed [31:0] s1_nlp_q [3];
  logic signed [15:0] s1_n_q [3];
  logic signed [15:0] s1_l_q [3];
  logic signed [15:0] s1_v_q [3];
  logic signed [32:0] nl_sum;
  logic signed [32:0] s2_nl_q;
  logic [16:0]        s2_cd_q;
  logic signed [15:0] s2_n_q [3];
  logic signed [15:0] s2_l_q [3];
  logic signed [15:0] s2_v_q [3];
  logic signed [48:0] s3_rp_q [3];
  logic signed [15:0] s3_l_q [3];
  logic signed [15:0] s3_v_q [3];
  logic [16:0]        s3_cd_q;
  logic signed [49:0] r_full [3];
  pps_pkg::wide_t     s4_r_q [3];
  logic signed [15:0] s4_v_q [3];
  logic [16:0]        s4_cd_q;
  pps_pkg::side_t     n2_side_i, n2_side_o;
  logic               n2_vld;
  pps_pkg::dir_t      n2_dir [3];

  logic signed [31:0] s5_vrp_q [3];
  logic [16:0]        s5_cd_q;
  logic signed [32:0] vr_sum;
  logic [16:0]        s6_cs_q;
  logic [16:0]        s6_cd_q;

  logic               pw_vld;
  logic [40:0]        pw_p;
  logic [16:0]        pw_cd;
  logic [31:0]        p_clip;
  logic [35:0]        f1_dif_q [3];
  logic [49:0]        f1_spec_q [3];
  logic [35:0]        dif_rnd [3];
  logic [49:0]        spec_rnd [3];
  logic [13:0]        amb_rnd [3];
  logic [8:0]         amb_q [3];
  logic [8:0]         dif_q [3];
  logic [8:0]         spec_q [3];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  assign pt[0]  = point_x_i;
  assign pt[1]  = point_y_i;
  assign pt[2]  = point_z_i;
  assign nin[0] = normal_x_i;
  assign nin[1] = normal_y_i;
  assign nin[2] = normal_z_i;
  assign vin[0] = view_x_i;
  assign vin[1] = view_y_i;
  assign vin[2] = view_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) begin
        light_q[j] <= '0;
        color_q[j] <= 9'd256;
      end
      dif_lvl_q  <= 9'd128;
      spec_lvl_q <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pps_pkg::CFG_LIGHT_X:    light_q[0] <= cfg_data_i;
        pps_pkg::CFG_LIGHT_Y:    light_q[1] <= cfg_data_i;
        pps_pkg::CFG_LIGHT_Z:    light_q[2] <= cfg_data_i;
        pps_pkg::CFG_COLOR_RED:  color_q[0] <= cfg_data_i[8:0];
        pps_pkg::CFG_COLOR_GRN:  color_q[1] <= cfg_data_i[8:0];
        pps_pkg::CFG_COLOR_BLU:  color_q[2] <= cfg_data_i[8:0];
        pps_pkg::CFG_DIF_LEVEL:  dif_lvl_q  <= cfg_data_i[8:0];
        pps_pkg::CFG_SPEC_LEVEL: spec_lvl_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = 17'(light_q[j]) - 17'(pt[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= accept;
      s1_vld_q <= n1_vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= n2_vld;
      s6_vld_q <= s5_vld_q;
      f1_vld_q <= pw_vld;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n1_side_i.nrm[j]  = s0_n_q[j];
      n1_side_i.view[j] = s0_v_q[j];
    end
    n1_side_i.cd = '0;
  end

  pps_normalize u_norm_light (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .vec_i   (s0_d_q),
    .side_i  (n1_side_i),
    .valid_o (n1_vld),
    .dir_o   (n1_dir),
    .side_o  (n1_side_o)
  );

  always_comb begin
    nl_sum = 33'(s1_nlp_q[0]) + 33'(s1_nlp_q[1]) + 33'(s1_nlp_q[2]);
    vr_sum = 33'(s5_vrp_q[0]) + 33'(s5_vrp_q[1]) + 33'(s5_vrp_q[2]);
    for (int j = 0; j < 3; j++) begin
      // Reflection before normalising: 2(N.L)N - L, both scaled to 42 fraction bits (Q2.28 times Q1.14).
      r_full[j] = (50'(s3_rp_q[j]) <<< 1) - (50'(s3_l_q[j]) <<< 28);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      kd_q[j]     <= 18'(color_q[j]) * 18'(dif_lvl_q);
      ks_q[j]     <= 18'(color_q[j]) * 18'(spec_lvl_q);

      s0_d_q[j]   <= {{31{diff[j][16]}}, diff[j]};
      s0_n_q[j]   <= nin[j];
      s0_v_q[j]   <= vin[j];

      s1_nlp_q[j] <= 32'($signed(n1_side_o.nrm[j])) * 32'(n1_dir[j]);
      s1_n_q[j]   <= $signed(n1_side_o.nrm[j]);
      s1_l_q[j]   <= n1_dir[j];
      s1_v_q[j]   <= $signed(n1_side_o.view[j]);

      s2_n_q[j]   <= s1_n_q[j];
      s2_l_q[j]   <= s1_l_q[j];
      s2_v_q[j]   <= s1_v_q[j];

      s3_rp_q[j]  <= 49'(s2_nl_q) * 49'(s2_n_q[j]);
      s3_l_q[j]   <= s2_l_q[j];
      s3_v_q[j]   <= s2_v_q[j];

      s4_r_q[j]   <= r_full[j][47:0];
      s4_v_q[j]   <= s3_v_q[j];

      s5_vrp_q[j] <= 32'($signed(n2_side_o.view[j])) * 32'(n2_dir[j]);
    end
    s2_nl_q <= nl_sum;
    s2_cd_q <= pps_pkg::clamp_dot(nl_sum);
    s3_cd_q <= s2_cd_q;
    s4_cd_q <= s3_cd_q;
    s5_cd_q <= n2_side_o.cd;
    s6_cs_q <= pps_pkg::clamp_dot(vr_sum);
    s6_cd_q <= s5_cd_q;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n2_side_i.nrm[j]  = '0;
      n2_side_i.view[j] = s4_v_q[j];
    end
    n2_side_i.cd = s4_cd_q;
  end

  pps_normalize u_norm_refl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .vec_i   (s4_r_q),
    .side_i  (n2_side_i),
    .valid_o (n2_vld),
    .dir_o   (n2_dir),
    .side_o  (n2_side_o)
  );

  pps_power u_power (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .cs_i    (s6_cs_q),
    .cd_i    (s6_cd_q),
    .valid_o (pw_vld),
    .pow_o   (pw_p),
    .cd_o    (pw_cd)
  );

  assign p_clip = (pw_p > SPEC_CLIP) ? 32'h8000_0000 : pw_p[31:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dif_rnd[j]  = f1_dif_q[j] + 36'd2097152;
      spec_rnd[j] = f1_spec_q[j] + 50'd2097152;
      amb_rnd[j]  = 14'(pps_pkg::AMBIENT_LEVEL) * 14'(color_q[j]) + 14'd128;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      f1_dif_q[j]  <= 36'(kd_q[j]) * 36'(pw_cd);
      f1_spec_q[j] <= 50'(ks_q[j]) * 50'(p_clip);
      amb_q[j]     <= pps_pkg::sat9(28'(amb_rnd[j][13:8]));
      dif_q[j]     <= pps_pkg::sat9(28'(dif_rnd[j][35:22]));
      spec_q[j]    <= pps_pkg::sat9(spec_rnd[j][49:22]);
    end
  end

  assign done_o       = f2_vld_q;
  assign amb_red_o    = amb_q[0];
  assign amb_green_o  = amb_q[1];
  assign amb_blue_o   = amb_q[2];
  assign dif_red_o    = dif_q[0];
  assign dif_green_o  = dif_q[1];
  assign dif_blue_o   = dif_q[2];
  assign spec_red_o   = spec_q[0];
  assign spec_green_o = spec_q[1];
  assign spec_blue_o  = spec_q[2];

`ifndef SYNTHESIS
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, pps_pkg::PIPE_LAT))
    else $error("result beat without a matching accepted item");

  a_item_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(pps_pkg::PIPE_LAT) done_o)
    else $error("accepted item produced no result beat");
`endif

endmodule
`default_nettype wire
